// ===== design/rle_gamma_cost_estimator_assert.svh =====
// Assertion macros for the run-length / gamma cost estimator checker.
// Needs clk and rst in scope at the point of use.
`ifndef RLE_GAMMA_COST_ESTIMATOR_ASSERT_SVH
`define RLE_GAMMA_COST_ESTIMATOR_ASSERT_SVH

// Checked outside reset only
`define RGCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included
`define RGCE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/rgce_pkg.sv =====
// Shared widths, request/reply codes, structs and helpers for the
// run-length / gamma cost estimator. No dependencies.
package rgce_pkg;

  localparam int CNT_W      = 32;   // histogram, total and run counters
  localparam int SYM_W      = 8;
  localparam int HIST_DEPTH = 1 << SYM_W;
  localparam int DIST_W     = SYM_W + 1;
  localparam int BITS_W     = 48;
  localparam int OUT_W      = 32;
  localparam int BPS_W      = 4;
  localparam int RUNS_W     = CNT_W + 1;
  localparam int PROD_W     = RUNS_W + BPS_W;
  localparam int SUM_W      = ((PROD_W > BITS_W) ? PROD_W : BITS_W) + 2;
  localparam int BL_W       = $clog2(CNT_W + 1);
  localparam int GAM_W      = BL_W + 1;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_DATA   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic KIND_COUNT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_SYMBOL = CFG_IDX_W'(1);

  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(HIST_DEPTH);
  localparam logic [BPS_W-1:0]  BPS_MAX  = BPS_W'(SYM_W);

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic              kind;
    logic [OUT_W-1:0]  count;
    logic [CNT_W-1:0]  tot;
    logic [CNT_W-1:0]  outsyms;
    logic [RUNS_W-1:0] runs;
    logic [DIST_W-1:0] ndist;
    logic [BPS_W-1:0]  bps;
    logic [BITS_W-1:0] gbits;
  } rpt_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [OUT_W-1:0] clip_out(input logic [RUNS_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w[63:OUT_W] != '0) ? '1 : w[OUT_W-1:0];
  endfunction

  function automatic logic [BITS_W-1:0] add_bits(input logic [BITS_W-1:0] a,
                                                 input logic [GAM_W-1:0]  g);
    logic [BITS_W:0] s;
    s = {1'b0, a} + (BITS_W+1)'(g);
    return s[BITS_W] ? '1 : s[BITS_W-1:0];
  endfunction

  // 2*bitlength-1, zero for an empty run
  function automatic logic [GAM_W-1:0] gamma_len(input logic [BL_W-1:0] bl);
    return (bl == '0) ? '0 : {bl, 1'b0} - GAM_W'(1);
  endfunction

  function automatic logic [BPS_W-1:0] bit_len8(input logic [SYM_W-1:0] v);
    logic [BPS_W-1:0] n;
    n = '0;
    for (int i = 0; i < SYM_W; i++) begin
      if (v[i]) n = BPS_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== design/rgce_hist.sv =====
// Byte histogram: synchronous memory with registered read, per-entry valid
// flops in place of a clearing pass, and write-to-read forwarding. Uses rgce_pkg.
module rgce_hist (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [rgce_pkg::SYM_W-1:0] rd_addr,
  input  rgce_pkg::hist_wr_t         wr,
  output logic [rgce_pkg::CNT_W-1:0] count
);
  import rgce_pkg::*;

  logic [CNT_W-1:0]      mem [HIST_DEPTH];
  logic [CNT_W-1:0]      rd_q;
  logic [HIST_DEPTH-1:0] vld;
  logic [SYM_W-1:0]      addr_q;
  logic                  fwd_hit;
  logic [CNT_W-1:0]      fwd_data;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr.en) vld[wr.addr] <= 1'b1;
      // read and write of the same entry on one edge: memory returns old word
      if (rd_en) fwd_hit <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= rd_addr;
      fwd_data <= wr.data;
    end
  end

  assign count = fwd_hit ? fwd_data : (vld[addr_q] ? rd_q : '0);

endmodule

// ===== design/rgce_report.sv =====
// Reply pipeline: product of bits-per-symbol and runs, byte estimate,
// clipping and the output register. Uses rgce_pkg.
module rgce_report (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rpt_valid,
  output logic                        rpt_ready,
  input  rgce_pkg::rpt_t              rpt,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        reply_kind,
  output logic [rgce_pkg::OUT_W-1:0]  symbol_count,
  output logic [rgce_pkg::OUT_W-1:0]  total_symbols,
  output logic [rgce_pkg::OUT_W-1:0]  output_symbols,
  output logic [rgce_pkg::OUT_W-1:0]  run_count,
  output logic [rgce_pkg::DIST_W-1:0] distinct_symbols,
  output logic [rgce_pkg::BITS_W-1:0] gamma_bits,
  output logic [rgce_pkg::BPS_W-1:0]  bits_per_symbol,
  output logic [rgce_pkg::BITS_W-1:0] estimated_bytes
);
  import rgce_pkg::*;

  logic              s2_v;
  rpt_t              s2;
  logic              s3_v;
  rpt_t              s3;
  logic [PROD_W-1:0] s3_prod;
  logic              s2_go;
  logic              s3_go;
  logic [SUM_W-1:0]  est_sum;
  logic [SUM_W-1:0]  est_q;

  assign s3_go     = s3_v && (!out_valid || out_ready);
  assign s2_go     = s2_v && (!s3_v || s3_go);
  assign rpt_ready = !s2_v || s2_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rpt_valid && rpt_ready) s2_v <= 1'b1;
      else if (s2_go)             s2_v <= 1'b0;
      if (s2_go)      s3_v <= 1'b1;
      else if (s3_go) s3_v <= 1'b0;
      if (s3_go)                       out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_valid && rpt_ready) s2 <= rpt;
    if (s2_go) begin
      s3      <= s2;
      s3_prod <= PROD_W'(s2.bps) * PROD_W'(s2.runs);
    end
  end

  assign est_sum = SUM_W'(7) + SUM_W'(s3.gbits) + SUM_W'(s3_prod);
  assign est_q   = est_sum >> 3;

  always_ff @(posedge clk) begin
    if (s3_go) begin
      reply_kind       <= s3.kind;
      symbol_count     <= s3.count;
      total_symbols    <= clip_out(RUNS_W'(s3.tot));
      output_symbols   <= clip_out(RUNS_W'(s3.outsyms));
      run_count        <= clip_out(s3.runs);
      distinct_symbols <= s3.ndist;
      gamma_bits       <= s3.gbits;
      bits_per_symbol  <= s3.bps;
      estimated_bytes  <= (est_q[SUM_W-1:BITS_W] != '0) ? '1 : est_q[BITS_W-1:0];
    end
  end

endmodule

// ===== design/rle_gamma_cost_estimator.sv =====
// Top level of the run-length / Elias gamma cost estimator.
// Uses rgce_pkg, rgce_hist and rgce_report.
//
//   channel   handshake               payload
//   cfg       cfg_we                  cfg_index, cfg_wdata
//   in        in_valid / in_ready     req_type, symbol
//   out       out_valid / out_ready   reply_kind .. estimated_bytes
//
// One word accepted per cycle unless stalled; replies pass s1, s2, s3, output reg.
// Histogram read on acceptance, written in the cycle after; same-entry hits forwarded.
// Reset is synchronous; per-entry valid flops replace a clearing sweep.
// A held output fills the three reply registers; the next query or finish then
// waits in the update stage and stalls the input, data words included.
module rle_gamma_cost_estimator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rgce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rgce_pkg::REQ_W-1:0]      req_type,
  input  logic [rgce_pkg::SYM_W-1:0]      symbol,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            reply_kind,
  output logic [rgce_pkg::OUT_W-1:0]      symbol_count,
  output logic [rgce_pkg::OUT_W-1:0]      total_symbols,
  output logic [rgce_pkg::OUT_W-1:0]      output_symbols,
  output logic [rgce_pkg::OUT_W-1:0]      run_count,
  output logic [rgce_pkg::DIST_W-1:0]     distinct_symbols,
  output logic [rgce_pkg::BITS_W-1:0]     gamma_bits,
  output logic [rgce_pkg::BPS_W-1:0]      bits_per_symbol,
  output logic [rgce_pkg::BITS_W-1:0]     estimated_bytes
);
  import rgce_pkg::*;

  logic              skip_enable;
  logic [SYM_W-1:0]  skip_symbol;

  logic              s1_valid;
  logic [REQ_W-1:0]  s1_req;
  logic [SYM_W-1:0]  s1_sym;
  logic              s1_needs_out;
  logic              s1_go;
  logic              in_fire;
  logic [SYM_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  h_count;
  hist_wr_t          hist_wr;

  logic [CNT_W-1:0]  total_count;
  logic [DIST_W-1:0] distinct_count;
  logic [CNT_W-1:0]  closed_runs;
  logic [BITS_W-1:0] bit_total;
  logic [SYM_W-1:0]  run_symbol;
  logic [CNT_W-1:0]  run_length;
  logic [BL_W-1:0]   run_bl;       // bit length of run_length, kept alongside it
  logic [CNT_W-1:0]  run_len_inc;
  logic              is_skip;
  logic [GAM_W-1:0]  cur_gamma;

  logic [DIST_W-1:0] dist_adj;
  logic [DIST_W-1:0] dist_m1;
  logic              rpt_valid;
  logic              rpt_ready;
  rpt_t              rpt;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_enable <= 1'b0;
      skip_symbol <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_ENABLE: skip_enable <= cfg_wdata[0];
        REG_SKIP_SYMBOL: skip_symbol <= cfg_wdata[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_needs_out = (s1_req == REQ_QUERY) || (s1_req == REQ_FINISH);
  assign s1_go        = s1_valid && (!s1_needs_out || rpt_ready);
  assign in_ready     = !rst && (!s1_valid || s1_go);
  assign in_fire      = in_valid && in_ready;
  // finish needs the skip byte's count
  assign rd_addr      = (req_type == REQ_FINISH) ? skip_symbol : symbol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req <= req_type;
      s1_sym <= symbol;
    end
  end

  assign hist_wr.en   = s1_go && (s1_req == REQ_DATA);
  assign hist_wr.addr = s1_sym;
  assign hist_wr.data = sat_inc(h_count);

  rgce_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .wr      (hist_wr),
    .count   (h_count)
  );

  assign is_skip     = skip_enable && (s1_sym == skip_symbol);
  assign run_len_inc = run_length + CNT_W'(1);
  assign cur_gamma   = gamma_len(run_bl);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count    <= '0;
      distinct_count <= '0;
      closed_runs    <= '0;
      bit_total      <= '0;
      run_symbol     <= '0;
      run_length     <= '0;
      run_bl         <= '0;
    end else if (hist_wr.en) begin
      if (h_count == '0 && distinct_count != DIST_MAX)
        distinct_count <= distinct_count + DIST_W'(1);
      total_count <= sat_inc(total_count);
      if (!is_skip) begin
        if (run_length != '0 && s1_sym == run_symbol) begin
          if (run_length != '1) begin
            run_length <= run_len_inc;
            // next length is a power of two: one more bit
            if ((run_length & run_len_inc) == '0) run_bl <= run_bl + BL_W'(1);
          end
        end else begin
          if (run_length != '0) begin
            closed_runs <= sat_inc(closed_runs);
            bit_total   <= add_bits(bit_total, cur_gamma);
          end
          run_symbol <= s1_sym;
          run_length <= CNT_W'(1);
          run_bl     <= BL_W'(1);
        end
      end
    end
  end

  assign dist_adj = (skip_enable && h_count != '0 && distinct_count != '0) ?
                    distinct_count - DIST_W'(1) : distinct_count;
  assign dist_m1  = dist_adj - DIST_W'(1);

  always_comb begin
    rpt = '0;
    if (s1_req == REQ_FINISH) begin
      rpt.kind    = KIND_SUMMARY;
      rpt.tot     = total_count;
      rpt.outsyms = skip_enable ?
                    ((total_count >= h_count) ? total_count - h_count : '0) :
                    total_count;
      rpt.runs    = RUNS_W'(closed_runs) + RUNS_W'(run_length != '0);
      rpt.ndist   = dist_adj;
      rpt.bps     = (dist_adj <= DIST_W'(1)) ? '0 : bit_len8(dist_m1[SYM_W-1:0]);
      rpt.gbits   = add_bits(bit_total, cur_gamma);
    end else begin
      rpt.kind  = KIND_COUNT;
      rpt.count = clip_out(RUNS_W'(h_count));
    end
  end

  assign rpt_valid = s1_valid && s1_needs_out;

  rgce_report u_report (
    .clk              (clk),
    .rst              (rst),
    .rpt_valid        (rpt_valid),
    .rpt_ready        (rpt_ready),
    .rpt              (rpt),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .reply_kind       (reply_kind),
    .symbol_count     (symbol_count),
    .total_symbols    (total_symbols),
    .output_symbols   (output_symbols),
    .run_count        (run_count),
    .distinct_symbols (distinct_symbols),
    .gamma_bits       (gamma_bits),
    .bits_per_symbol  (bits_per_symbol),
    .estimated_bytes  (estimated_bytes)
  );

endmodule

// ===== design/rgce_checker.sv =====
// Port-level checks for rle_gamma_cost_estimator, bound to the top level.
// Uses rgce_pkg and rle_gamma_cost_estimator_assert.svh.
`include "rle_gamma_cost_estimator_assert.svh"

module rgce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        reply_kind,
  input logic [rgce_pkg::OUT_W-1:0]  symbol_count,
  input logic [rgce_pkg::OUT_W-1:0]  total_symbols,
  input logic [rgce_pkg::OUT_W-1:0]  output_symbols,
  input logic [rgce_pkg::OUT_W-1:0]  run_count,
  input logic [rgce_pkg::DIST_W-1:0] distinct_symbols,
  input logic [rgce_pkg::BITS_W-1:0] gamma_bits,
  input logic [rgce_pkg::BPS_W-1:0]  bits_per_symbol,
  input logic [rgce_pkg::BITS_W-1:0] estimated_bytes
);
  import rgce_pkg::*;

  // no ready during reset, no reply on the edge after it
  `RGCE_ASSERT_RST(a_rst_quiet, rst |-> (!in_ready ##1 !out_valid), "reply or ready in reset")

  // a count reply carries nothing but the count
  `RGCE_ASSERT(a_count_clean, (out_valid && reply_kind == KIND_COUNT) |-> (total_symbols == '0 && output_symbols == '0 && run_count == '0 && distinct_symbols == '0 && gamma_bits == '0 && bits_per_symbol == '0 && estimated_bytes == '0), "count reply with summary fields set")

  `RGCE_ASSERT(a_summary_sane, (out_valid && reply_kind == KIND_SUMMARY) |-> (symbol_count == '0 && output_symbols <= total_symbols && distinct_symbols <= DIST_MAX && bits_per_symbol <= BPS_MAX && (distinct_symbols > 9'd1 || bits_per_symbol == '0)), "inconsistent summary word")

  `RGCE_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(reply_kind) && $stable(symbol_count) && $stable(estimated_bytes)), "reply changed while stalled")

endmodule

bind rle_gamma_cost_estimator rgce_checker u_rgce_checker (.*);

// ===== tb/rle_gamma_cost_estimator_tb.sv =====
// Self-checking testbench for rle_gamma_cost_estimator: directed and random byte
// streams with queries and finish words, random stalls on both sides, config changes.
// Depends on rgce_pkg and the RTL only.
module rle_gamma_cost_estimator_tb;
  import rgce_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic              kind;
    logic [OUT_W-1:0]  count;
    logic [OUT_W-1:0]  tot;
    logic [OUT_W-1:0]  outsyms;
    logic [OUT_W-1:0]  runs;
    logic [DIST_W-1:0] ndist;
    logic [BITS_W-1:0] gbits;
    logic [BPS_W-1:0]  bps;
    logic [BITS_W-1:0] est;
  } reply_t;

  // Histogram, run tracker and cost totals, plus the replies still owed
  class cost_tracker;
    bit [31:0] hist [256];
    bit [31:0] total;
    bit [31:0] closed;
    bit [8:0]  distinct;
    bit [47:0] bits_sum;
    bit [7:0]  run_sym;
    bit [31:0] run_len;
    bit        skip_en;
    bit [7:0]  skip_sym;
    reply_t    replies_due [$];
    int        errors;
    int        n_checked;

    function bit [31:0] sat_inc32(bit [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function bit [63:0] bitlen(bit [63:0] v);
      bit [63:0] n;
      n = 0;
      for (int i = 0; i < 64; i++)
        if (v[i]) n = i + 1;
      return n;
    endfunction

    function bit [47:0] add_sat48(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function bit [63:0] gamma_cost(bit [31:0] len);
      return (len == 0) ? 64'd0 : 2 * bitlen(64'(len)) - 1;
    endfunction

    function bit [63:0] clip(bit [63:0] v, bit [63:0] lim);
      return (v > lim) ? lim : v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SKIP_ENABLE)
        skip_en = val[0];
      else if (idx == REG_SKIP_SYMBOL)
        skip_sym = val;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void take_word(logic [REQ_W-1:0] req, logic [SYM_W-1:0] sym);
      reply_t r;
      bit [63:0] tot, outsyms, runs, gb, h, bps, est;
      bit [8:0] ndist;
      r = '0;
      case (req)
        REQ_DATA: begin
          if (hist[sym] == 0 && distinct < 256) distinct++;
          hist[sym] = sat_inc32(hist[sym]);
          total = sat_inc32(total);
          // skip byte neither breaks nor extends the open run
          if (!(skip_en && sym == skip_sym)) begin
            if (run_len != 0 && sym == run_sym) begin
              run_len = sat_inc32(run_len);
            end else begin
              if (run_len != 0) begin
                closed = sat_inc32(closed);
                bits_sum = add_sat48(64'(bits_sum), gamma_cost(run_len));
              end
              run_sym = sym;
              run_len = 1;
            end
          end
        end
        REQ_QUERY: begin
          r.kind = KIND_COUNT;
          r.count = hist[sym];
          replies_due.push_back(r);
        end
        REQ_FINISH: begin
          tot = total;
          outsyms = tot;
          ndist = distinct;
          runs = closed;
          gb = bits_sum;
          if (skip_en) begin
            h = hist[skip_sym];
            outsyms = (tot >= h) ? tot - h : 64'd0;
            if (h != 0 && ndist > 0) ndist--;
          end
          // pending run counts only when one is open
          if (run_len != 0) begin
            runs = runs + 1;
            gb = add_sat48(gb, gamma_cost(run_len));
          end
          bps = (ndist <= 1) ? 64'd0 : bitlen(64'(ndist) - 1);
          est = (7 + gb + bps * runs) / 8;
          r.kind = KIND_SUMMARY;
          r.tot = tot[31:0];
          r.outsyms = outsyms[31:0];
          r.runs = clip(runs, 64'hFFFF_FFFF);
          r.ndist = ndist;
          r.gbits = gb[47:0];
          r.bps = bps[3:0];
          r.est = clip(est, 64'hFFFF_FFFF_FFFF);
          replies_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void cmp(string fname, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("reply %0d: %s mismatch, expected 0x%0h, got 0x%0h",
                   n_checked, fname, want, got);
      end
    endfunction

    function void check_reply(reply_t seen);
      reply_t want;
      n_checked++;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("reply %0d: unexpected word, kind %0d", n_checked, seen.kind);
        return;
      end
      want = replies_due.pop_front();
      cmp("reply_kind", 64'(want.kind), 64'(seen.kind));
      cmp("symbol_count", 64'(want.count), 64'(seen.count));
      cmp("total_symbols", 64'(want.tot), 64'(seen.tot));
      cmp("output_symbols", 64'(want.outsyms), 64'(seen.outsyms));
      cmp("run_count", 64'(want.runs), 64'(seen.runs));
      cmp("distinct_symbols", 64'(want.ndist), 64'(seen.ndist));
      cmp("gamma_bits", 64'(want.gbits), 64'(seen.gbits));
      cmp("bits_per_symbol", 64'(want.bps), 64'(seen.bps));
      cmp("estimated_bytes", 64'(want.est), 64'(seen.est));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [REQ_W-1:0]      req_type;
  logic [SYM_W-1:0]      symbol;
  logic                  out_valid;
  logic                  out_ready;
  logic                  reply_kind;
  logic [OUT_W-1:0]      symbol_count;
  logic [OUT_W-1:0]      total_symbols;
  logic [OUT_W-1:0]      output_symbols;
  logic [OUT_W-1:0]      run_count;
  logic [DIST_W-1:0]     distinct_symbols;
  logic [BITS_W-1:0]     gamma_bits;
  logic [BPS_W-1:0]      bits_per_symbol;
  logic [BITS_W-1:0]     estimated_bytes;

  cost_tracker sb;
  bit          idle_on;
  bit          hold_req;
  int          cycles;

  rle_gamma_cost_estimator u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .symbol           (symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .reply_kind       (reply_kind),
    .symbol_count     (symbol_count),
    .total_symbols    (total_symbols),
    .output_symbols   (output_symbols),
    .run_count        (run_count),
    .distinct_symbols (distinct_symbols),
    .gamma_bits       (gamma_bits),
    .bits_per_symbol  (bits_per_symbol),
    .estimated_bytes  (estimated_bytes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reply monitor: values seen here are the ones before this edge
  always @(posedge clk) begin
    reply_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.kind    = reply_kind;
      seen.count   = symbol_count;
      seen.tot     = total_symbols;
      seen.outsyms = output_symbols;
      seen.runs    = run_count;
      seen.ndist   = distinct_symbols;
      seen.gbits   = gamma_bits;
      seen.bps     = bits_per_symbol;
      seen.est     = estimated_bytes;
      sb.check_reply(seen);
    end
  end

  // Receiver: ready bursts, random stalls, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [REQ_W-1:0] rq, input logic [SYM_W-1:0] sy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    symbol   <= sy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_word(rq, sy);
  endtask

  // Data words give no reply, so allow the pipeline to empty after the last one
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [SYM_W-1:0] sym);
    logic [CFG_DATA_W-1:0] en_word;
    en_word = {7'($urandom()), en};
    cfg_we    <= 1'b1;
    cfg_index <= REG_SKIP_ENABLE;
    cfg_wdata <= en_word;
    @(posedge clk);
    sb.set_reg(REG_SKIP_ENABLE, en_word);
    cfg_index <= REG_SKIP_SYMBOL;
    cfg_wdata <= sym;
    @(posedge clk);
    sb.set_reg(REG_SKIP_SYMBOL, sym);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int sent;
    int pick;
    int len;
    logic [SYM_W-1:0] sy;
    logic [SYM_W-1:0] pool [4];
    pool[0] = 8'h00;
    pool[1] = 8'hFF;
    pool[2] = 8'($urandom());
    pool[3] = 8'($urandom());
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // a run, now and then with skip bytes inside it
        sy = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 3)] : 8'($urandom());
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 100) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if (sb.skip_en && $urandom_range(0, 9) == 0) begin
            send_item(REQ_DATA, sb.skip_sym);
            sent++;
          end
          send_item(REQ_DATA, sy);
          sent++;
        end
      end else if (pick < 49) begin
        // ascending sweep, fills the histogram towards all 256 values
        sy = 8'($urandom());
        len = $urandom_range(16, 64);
        for (int k = 0; k < len; k++) begin
          send_item(REQ_DATA, sy);
          sy = sy + 8'd1;
          sent++;
        end
      end else if (pick < 70) begin
        send_item(REQ_DATA, 8'($urandom()));
        sent++;
      end else if (pick < 87) begin
        sy = ($urandom_range(0, 3) == 0) ? sb.skip_sym : 8'($urandom());
        send_item(REQ_QUERY, sy);
        sent++;
      end else if (pick < 96) begin
        send_item(REQ_FINISH, 8'($urandom()));
        sent++;
      end else begin
        send_item(REQ_UNUSED, 8'($urandom()));
      end
    end
  endtask

  initial begin
    sb        = new();
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    req_type  = REQ_DATA;
    symbol    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset config: empty stream, extremes, ignored request type
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_QUERY, 8'h00);
    send_item(REQ_QUERY, 8'hFF);
    send_item(REQ_DATA, 8'h00);
    send_item(REQ_DATA, 8'h00);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_UNUSED, 8'hAA);
    send_item(REQ_QUERY, 8'h00);
    send_item(REQ_FINISH, 8'hFF);
    send_item(REQ_DATA, 8'h55);
    send_item(REQ_DATA, 8'h55);
    send_item(REQ_FINISH, 8'h00);
    drain();

    // skip byte set mid-stream; open run carries over, skip bytes sit inside a run
    set_config(1'b1, 8'hFF);
    send_item(REQ_DATA, 8'h10);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_DATA, 8'h10);
    send_item(REQ_DATA, 8'h10);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_QUERY, 8'hFF);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_QUERY, 8'h10);
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_UNUSED, 8'h5A);
    drain();

    set_config(1'b0, 8'h00);
    random_phase(340);
    drain();

    set_config(1'b1, 8'h00);
    random_phase(170);
    // long hold-off on the reply side while queries keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_item(REQ_QUERY, 8'($urandom()));
    random_phase(170);
    drain();

    set_config(1'b1, 8'($urandom()));
    random_phase(340);
    drain();

    set_config(1'b0, 8'($urandom()));
    random_phase(340);
    drain();

    idle_on = 1'b0;
    set_config(1'b1, 8'hFF);
    random_phase(420);
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
